FILE: rtl/sst_pkg.sv
// Shared types and constants for the sorted set table.
// Used by the command queue, the cell array and the top level.
package sst_pkg;

  localparam int KEY_W = 64;
  localparam int CMD_W = 2;
  localparam int OUT_CNT_W = 7;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_SPARE  = 2'd3
  } cmd_t;

  // One queued command item.
  typedef struct packed {
    cmd_t                    cmd;
    logic signed [KEY_W-1:0] key;
  } item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_APPLY
  } state_t;

endpackage

FILE: rtl/sst_front.sv
// Front end: accepts command items and holds them in a two-entry queue.
// Depends on sst_pkg for the item type.
module sst_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [sst_pkg::KEY_W-1:0] s_tdata,
  input  logic [sst_pkg::CMD_W-1:0] s_tuser,
  output logic                     q_valid,
  input  logic                     q_ready,
  output sst_pkg::item_t           q_item
);
  import sst_pkg::*;

  item_t      slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       push;
  logic       pop;

  assign s_tready = (fill != 2'd2);
  assign q_valid  = (fill != 2'd0);
  assign q_item   = slots[rd_ptr];
  assign push     = s_tvalid && s_tready;
  assign pop      = q_valid && q_ready;

  // Queue storage; payload needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= '{cmd: cmd_t'(s_tuser), key: s_tdata};
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

FILE: rtl/sst_cells.sv
// Back end: a row of sorted key cells that compare in parallel and shift.
// Depends on sst_pkg; takes items from the front queue, drives the result register.
module sst_cells #(
  parameter int CAPACITY = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  output logic           q_ready,
  input  sst_pkg::item_t q_item,
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [15:0]    m_tdata
);
  import sst_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  logic signed [KEY_W-1:0] store [CAPACITY];
  logic [CW-1:0]           count;
  item_t                   cur;
  logic [CAPACITY-1:0]     lt_vec;
  logic [CAPACITY-1:0]     eq_vec;
  state_t                  state;
  state_t                  state_next;
  logic                    take;
  logic                    apply;
  logic                    out_free;
  logic [CAPACITY-1:0]     bnd;
  logic [CW-1:0]           pos;
  logic                    hit;
  logic                    do_ins;
  logic                    do_rem;
  logic [CW-1:0]           count_next;
  logic [31:0]             pos_wide;
  logic [31:0]             cnt_wide;

  assign out_free = !m_tvalid || m_tready;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (q_valid) state_next = ST_CMP;
      ST_CMP:   state_next = ST_APPLY;
      ST_APPLY: if (out_free) state_next = q_valid ? ST_CMP : ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    apply = (state == ST_APPLY) && out_free;
    take  = q_valid && ((state == ST_IDLE) || apply);
  end
  assign q_ready = take;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // Latch the command that is taken from the queue.
  always_ff @(posedge clk) begin
    if (take) cur <= q_item;
  end

  // Every live cell compares its key with the command key.
  always_ff @(posedge clk) begin
    if (state == ST_CMP) begin
      for (int i = 0; i < CAPACITY; i++) begin
        lt_vec[i] <= (CW'(i) < count) && (store[i] < cur.key);
        eq_vec[i] <= (CW'(i) < count) && (store[i] == cur.key);
      end
    end
  end

  // The less-than flags form a thermometer; its edge gives the position.
  always_comb begin
    pos = lt_vec[CAPACITY-1] ? CW'(CAPACITY) : '0;
    for (int i = 0; i < CAPACITY; i++) begin
      bnd[i] = ((i == 0) ? 1'b1 : lt_vec[(i == 0) ? 0 : i-1]) && !lt_vec[i];
      if (bnd[i]) pos = pos | CW'(i);
    end
    hit    = |eq_vec;
    do_ins = (cur.cmd == CMD_INSERT) && !hit && (count < CW'(CAPACITY));
    do_rem = (cur.cmd == CMD_REMOVE) && hit;
    count_next = count;
    if (do_ins) count_next = count + 1'b1;
    else if (do_rem) count_next = count - 1'b1;
  end

  // Cells shift up on insert and down on remove above the position.
  always_ff @(posedge clk) begin
    if (apply) begin
      for (int i = 0; i < CAPACITY; i++) begin
        if (do_ins && !lt_vec[i]) begin
          if (bnd[i]) store[i] <= cur.key;
          else if (i > 0) store[i] <= store[(i > 0) ? i-1 : 0];
        end else if (do_rem && !lt_vec[i] && (i < CAPACITY - 1)) begin
          store[i] <= store[(i < CAPACITY - 1) ? i+1 : i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst)        count <= '0;
    else if (apply) count <= count_next;
  end

  // Result register: found, position, entry count, status.
  assign pos_wide = 32'(pos);
  assign cnt_wide = 32'(count_next);
  always_ff @(posedge clk) begin
    if (apply) begin
      m_tdata <= {((cur.cmd == CMD_INSERT) && !hit && !do_ins),
                  cnt_wide[OUT_CNT_W-1:0], pos_wide[OUT_CNT_W-1:0], hit};
    end
  end

  always_ff @(posedge clk) begin
    if (rst)           m_tvalid <= 1'b0;
    else if (apply)    m_tvalid <= 1'b1;
    else if (m_tready) m_tvalid <= 1'b0;
  end

endmodule

FILE: rtl/sorted_set_table.sv
// Sorted set table: every command item passes the cell array as a parallel compare state
// and then a shift and result write state; a new item is taken only as the last is applied.
// The result is registered and waits in its register while the receiver stalls.
// The cell compare and shift loop sets the rate. Reset clears the entry count,
// the queue and the result valid flag; key cells are not cleared.
module sorted_set_table #(
  parameter int CAPACITY = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,  // key[63:0]
  input  logic [1:0]  s_tuser,  // cmd[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata   // found[0], position[7:1], entry_count[14:8], status[15]
);
  import sst_pkg::*;

  logic  q_valid;
  logic  q_ready;
  item_t q_item;

  sst_front u_front (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .q_valid, .q_ready, .q_item
  );

  sst_cells #(.CAPACITY(CAPACITY)) u_cells (
    .clk, .rst, .q_valid, .q_ready, .q_item, .m_tvalid, .m_tready, .m_tdata
  );

endmodule

FILE: rtl/sst_checker.sv
// Port checker for the sorted set table, bound to the top level.
// Depends only on the top-level ports.
module sst_checker #(
  parameter int CAPACITY = 64
) (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata
);

  // A stalled result stays offered.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid) else $error("result dropped");

  // A refused insert never reports a present key.
  a_full_nf: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[15] |-> !m_tdata[0]) else $error("refused but found");

  // A refused insert comes only from a full table.
  a_full_cnt: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[15] |-> (m_tdata[14:8] == 7'(CAPACITY)))
    else $error("refused below capacity");

  // No result directly after reset.
  a_rst: assert property (@(posedge clk) $past(rst) |-> !m_tvalid)
    else $error("result after reset");

endmodule

bind sorted_set_table sst_checker #(.CAPACITY(CAPACITY)) u_sst_checker (
  .clk, .rst, .m_tvalid, .m_tready, .m_tdata
);

FILE: verif/sorted_set_table_tb.sv
// Self-checking testbench for the sorted set table: lookup, insert and remove commands
// drive a directed table, then random traffic; results are checked against a local model.
// Depends on sst_pkg and the sorted_set_table RTL.
`timescale 1ns / 1ps

module sorted_set_table_tb;
  import sst_pkg::*;

  localparam int CAP = 64;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic       status;
    logic [6:0] entry_count;
    logic [6:0] position;
    logic       found;
  } reply_t;

  typedef struct {
    cmd_t                    cmd;
    logic signed [KEY_W-1:0] key;
    bit                      has_exp;
    reply_t                  exp;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [63:0] s_tdata = '0;
  logic [1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [15:0] m_tdata;

  // Local copy of the table contents.
  logic signed [KEY_W-1:0] table_keys[$];
  reply_t expected_replies[$];
  reply_t typed_replies[$];
  bit typed_valid[$];

  int mismatch_count = 0;
  int idle_cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  sorted_set_table #(.CAPACITY(CAP)) u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #6 clk = ~clk;

  // Apply one command to the local table and return the reply it causes.
  function automatic reply_t apply_command(cmd_t cmd, logic signed [KEY_W-1:0] key);
    reply_t r;
    int pos;
    bit hit;
    pos = 0;
    while (pos < table_keys.size() && table_keys[pos] < key) pos++;
    hit = (pos < table_keys.size()) && (table_keys[pos] == key);
    r = '0;
    if (cmd == CMD_INSERT && !hit) begin
      if (table_keys.size() >= CAP) r.status = 1'b1;
      else table_keys.insert(pos, key);
    end else if (cmd == CMD_REMOVE && hit) begin
      table_keys.delete(pos);
    end
    r.found = hit;
    r.position = 7'(pos);
    r.entry_count = 7'(table_keys.size());
    return r;
  endfunction

  // Drive one command and wait for its acceptance; valid stays up for a following item.
  task automatic send_command(cmd_t cmd, logic signed [KEY_W-1:0] key, bit has_exp,
                              reply_t typed);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= key;
    s_tuser <= cmd;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    expected_replies.push_back(apply_command(cmd, key));
    typed_replies.push_back(typed);
    typed_valid.push_back(has_exp);
  endtask

  // Receiver stalls at random.
  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Compare each accepted reply with the oldest expectation.
  always @(posedge clk) begin
    reply_t got;
    reply_t want;
    bit bad;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      if (expected_replies.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("Unexpected reply %h", m_tdata);
      end else begin
        want = expected_replies.pop_front();
        bad = (got.found !== want.found) || (got.position !== want.position) ||
              (got.entry_count !== want.entry_count) || (got.status !== want.status);
        if (typed_valid.pop_front()) begin
          if (typed_replies.pop_front() !== want) begin
            bad = 1'b1;
          end
        end else begin
          void'(typed_replies.pop_front());
        end
        if (bad) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display({"Mismatch: expected found=%0d pos=%0d count=%0d status=%0d, ",
                      "got found=%0d pos=%0d count=%0d status=%0d"},
                     want.found, want.position, want.entry_count, want.status,
                     got.found, got.position, got.entry_count, got.status);
        end
      end
    end
  end

  // Watchdog on cycles without any accepted item.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic logic signed [KEY_W-1:0] rand_key();
    return {$urandom(), $urandom()};
  endfunction

  // Pick a key that is often already stored, to hit found paths.
  function automatic logic signed [KEY_W-1:0] pick_key(logic signed [KEY_W-1:0] pool[$]);
    int sel;
    sel = $urandom_range(9);
    if (sel < 5 && table_keys.size() > 0)
      return table_keys[$urandom_range(table_keys.size() - 1)];
    if (sel < 8) return pool[$urandom_range(pool.size() - 1)];
    return rand_key();
  endfunction

  initial begin
    row_t rows[$];
    row_t r;
    logic signed [KEY_W-1:0] pool[$];
    logic signed [KEY_W-1:0] k;
    cmd_t c;
    int sel;
    reply_t rp;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed rows: empty table, extremes, spare command, duplicates, absent remove.
    r.has_exp = 1'b1;
    r.cmd = CMD_LOOKUP; r.key = 64'sh0; r.exp = '{0, 7'd0, 7'd0, 0}; rows.push_back(r);
    r.cmd = CMD_REMOVE; r.key = 64'sh5; r.exp = '{0, 7'd0, 7'd0, 0}; rows.push_back(r);
    r.cmd = CMD_INSERT; r.key = 64'sh7FFFFFFFFFFFFFFF; r.exp = '{0, 7'd1, 7'd0, 0};
    rows.push_back(r);
    r.cmd = CMD_INSERT; r.key = 64'sh8000000000000000; r.exp = '{0, 7'd2, 7'd0, 0};
    rows.push_back(r);
    r.has_exp = 1'b0;
    r.cmd = CMD_INSERT; r.key = 64'sh0000000100000000; rows.push_back(r);
    r.cmd = CMD_INSERT; r.key = -64'sh0000000080000000; rows.push_back(r);
    r.cmd = CMD_INSERT; r.key = 64'sh0000000100000000; rows.push_back(r);
    r.cmd = CMD_SPARE; r.key = 64'sh7FFFFFFFFFFFFFFF; rows.push_back(r);
    r.cmd = CMD_LOOKUP; r.key = 64'sh8000000000000000; rows.push_back(r);
    r.cmd = CMD_REMOVE; r.key = 64'sh0000000000000001; rows.push_back(r);
    r.cmd = CMD_REMOVE; r.key = 64'sh8000000000000000; rows.push_back(r);
    r.cmd = CMD_LOOKUP; r.key = -64'sh1; rows.push_back(r);
    r.cmd = CMD_REMOVE; r.key = 64'sh7FFFFFFFFFFFFFFF; rows.push_back(r);
    r.cmd = CMD_SPARE; r.key = 64'shAAAAAAAAAAAAAAAA; rows.push_back(r);
    r.cmd = CMD_INSERT; r.key = 64'sh5555555555555555; rows.push_back(r);
    foreach (rows[i]) begin
      rp = '0;
      if (rows[i].has_exp) rp = rows[i].exp;
      send_command(rows[i].cmd, rows[i].key, rows[i].has_exp, rp);
    end

    for (int i = 0; i < 24; i++) pool.push_back(rand_key());
    pool.push_back(64'sh8000000000000000);
    pool.push_back(64'sh7FFFFFFFFFFFFFFF);

    // Random phases: no idling, sender idle, receiver stall, both.
    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct = (phase == 1) ? 79 : (phase == 3) ? 8 : 0;
      recv_stall_pct = (phase == 2) ? 79 : (phase == 3) ? 8 : 0;
      for (int n = 0; n < 340; n++) begin
        // Fill toward capacity in bursts, drain in others, so full-table refusals occur.
        sel = $urandom_range(99);
        if (n % 170 < 100) c = (sel < 70) ? CMD_INSERT : (sel < 85) ? CMD_LOOKUP : CMD_REMOVE;
        else c = (sel < 65) ? CMD_REMOVE : (sel < 80) ? CMD_INSERT :
                 (sel < 95) ? CMD_LOOKUP : CMD_SPARE;
        k = (c == CMD_INSERT && $urandom_range(3) != 0) ? rand_key() : pick_key(pool);
        send_command(c, k, 1'b0, '0);
      end
    end
    s_tvalid <= 1'b0;

    while (expected_replies.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
